/* hw/rtl/stu_pkg.sv */
`timescale 1ns / 1ps
package stu_pkg;

  // fixed point formats
  localparam int POS_FRAC_BITS  = 16;
  localparam int QUAT_FRAC_BITS = 15;
  localparam int POS_W          = 32;
  localparam int QUAT_W         = 16;

  // stream widths
  localparam int TDATA_W = 3 * POS_W + 4 * QUAT_W + POS_W;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;

  // apb address width: eight registers of four bytes
  localparam int ADDR_W = 5;

  // reciprocal numerator 2^(2F) + |s|/2 needs this many bits
  localparam int DIV_W = ((2 * POS_FRAC_BITS > 30) ? 2 * POS_FRAC_BITS : 30) + 1;

  // product and sum widths of the rotation
  localparam int P1_W = POS_W + QUAT_W;
  localparam int S1_W = P1_W + 2;
  localparam int T_W  = S1_W - QUAT_FRAC_BITS;
  localparam int P2_W = T_W + QUAT_W;
  localparam int MUL_W = 2 * POS_W;
  localparam int QP_W  = 2 * QUAT_W;

  // register indexes
  localparam logic [2:0] REG_LEFT_POS_X  = 3'd0;
  localparam logic [2:0] REG_LEFT_POS_Y  = 3'd1;
  localparam logic [2:0] REG_LEFT_POS_Z  = 3'd2;
  localparam logic [2:0] REG_LEFT_QW     = 3'd3;
  localparam logic [2:0] REG_LEFT_QX     = 3'd4;
  localparam logic [2:0] REG_LEFT_QY     = 3'd5;
  localparam logic [2:0] REG_LEFT_QZ     = 3'd6;
  localparam logic [2:0] REG_LEFT_SCALE  = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT      = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_INV = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_COMPOSE   = 3'd0,
    FN_APPLY     = 3'd1,
    FN_INVERT    = 3'd2,
    FN_LQUAT     = 3'd3,
    FN_QUAT_IN   = 3'd4,
    FN_TRANSLATE = 3'd5,
    FN_SCALE     = 3'd6,
    FN_NONE      = 3'd7
  } func_t;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [127:0]      wide_t;

  // one item as it travels down the pipe
  typedef struct packed {
    func_t           func;
    pos_t  [2:0]     pos;
    quat_t [3:0]     q;
    pos_t            scale;
    logic            flag;
    logic            zinv;
  } item_t;

  // round half up then arithmetic shift
  function automatic wide_t rnd(input wide_t x, input int s);
    return (x + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic ovf32(input wide_t x);
    return (x > wide_t'(32'sh7fffffff)) || (x < wide_t'(32'sh80000000));
  endfunction

  function automatic pos_t sat32(input wide_t x);
    if (x > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (x < wide_t'(32'sh80000000)) return 32'sh80000000;
    return pos_t'(x);
  endfunction

  function automatic logic ovf16(input wide_t x);
    return (x > wide_t'(16'sh7fff)) || (x < wide_t'(16'sh8000));
  endfunction

  function automatic quat_t sat16(input wide_t x);
    if (x > wide_t'(16'sh7fff)) return 16'sh7fff;
    if (x < wide_t'(16'sh8000)) return 16'sh8000;
    return quat_t'(x);
  endfunction

endpackage

/* hw/rtl/similarity_transform_unit.sv */
`timescale 1ns / 1ps
// similarity transform unit
// applies a left transform L (position, unit quaternion, uniform scale, held
// in apb registers) to a stream of operands: compose, point apply, inverse,
// quaternion products, translate and scale, selected per beat by s_tuser.
// input beat: s_tdata carries pos x/y/z, qw/qx/qy/qz and scale, s_tuser the
// function code. output beat: m_tdata the same layout, m_tuser the status
// (ok, saturated, inverse of zero scale).
// data path: the input register, then the reciprocal divider, one quotient
// bit per stage, then the rotate and multiply stages.
// throughput: one beat per cycle while the receiver does not stall; every
// function code takes the same path.
// reset clears all valid bits and loads L with the identity transform.
// when the receiver stalls with a result waiting, the whole pipe holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// registers are to be written only while the pipe is empty; the block
// itself does not enforce this.
module similarity_transform_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pos_x, pos_y, pos_z, qw, qx, qy, qz, scale
  input  logic [stu_pkg::TDATA_W-1:0]   s_tdata,
  // func
  input  logic [stu_pkg::FUNC_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pos_x, pos_y, pos_z, qw, qx, qy, qz, scale
  output logic [stu_pkg::TDATA_W-1:0]   m_tdata,
  // status
  output logic [stu_pkg::STAT_W-1:0]    m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stu_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import stu_pkg::*;

  // left transform registers
  pos_t  left_pos [3];
  quat_t left_q   [4];
  pos_t  left_scale;

  logic en;

  // divider pipe, index 0 is the input register
  logic                 d_vld [DIV_W+1];
  item_t                d_it  [DIV_W+1];
  logic [POS_W-1:0]     d_mag [DIV_W+1];
  logic [POS_W:0]       d_rem [DIV_W+1];
  logic [DIV_W-1:0]     d_num [DIV_W+1];
  logic [DIV_W-1:0]     d_quo [DIV_W+1];

  logic                 m0_vld, m1_vld, m2_vld;
  item_t                m0_it, m1_it, m2_it, m0_it_next;
  logic signed [MUL_W-1:0] m1_prod [3];
  pos_t                 m2_vec [3];

  logic                 r1_vld, r2_vld, r3_vld, r4_vld;
  item_t                r1_it, r2_it, r3_it, r4_it;
  quat_t                r1_q [4];
  quat_t                r2_q [4];
  logic signed [P1_W-1:0] r1_p [12];
  logic signed [T_W-1:0]  r2_t [4];
  logic signed [P2_W-1:0] r3_p [12];
  pos_t                 r4_r [3];

  logic                 s1_vld, s2_vld;
  item_t                s1_it, s2_it;
  logic signed [MUL_W-1:0] s1_pp [3];
  logic signed [QP_W-1:0]  s1_qp [4][4];
  logic signed [MUL_W-1:0] s1_sp;
  pos_t                 s1_r [3];
  pos_t                 s2_r [3];
  pos_t                 s2_pos [3];
  quat_t                s2_q [4];
  pos_t                 s2_s;

  logic                 o_vld;
  pos_t                 o_pos [3];
  quat_t                o_q [4];
  pos_t                 o_scale;
  logic [STAT_W-1:0]    o_status;

  logic [POS_W-1:0]     in_mag;
  pos_t                 in_scale;

  // pipe advances unless a result waits
  assign en       = !o_vld || m_tready;
  assign s_tready = en;
  assign pready   = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pos[0] <= '0;
      left_pos[1] <= '0;
      left_pos[2] <= '0;
      left_q[0]   <= 16'sh7fff;
      left_q[1]   <= '0;
      left_q[2]   <= '0;
      left_q[3]   <= '0;
      left_scale  <= pos_t'(1) <<< POS_FRAC_BITS;
    end else if (psel && penable && pwrite) begin
      case (paddr[ADDR_W-1:2])
        REG_LEFT_POS_X: left_pos[0] <= pwdata;
        REG_LEFT_POS_Y: left_pos[1] <= pwdata;
        REG_LEFT_POS_Z: left_pos[2] <= pwdata;
        REG_LEFT_QW:    left_q[0]   <= pwdata[QUAT_W-1:0];
        REG_LEFT_QX:    left_q[1]   <= pwdata[QUAT_W-1:0];
        REG_LEFT_QY:    left_q[2]   <= pwdata[QUAT_W-1:0];
        REG_LEFT_QZ:    left_q[3]   <= pwdata[QUAT_W-1:0];
        REG_LEFT_SCALE: left_scale  <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_LEFT_POS_X: prdata = left_pos[0];
      REG_LEFT_POS_Y: prdata = left_pos[1];
      REG_LEFT_POS_Z: prdata = left_pos[2];
      REG_LEFT_QW:    prdata = {16'b0, left_q[0]};
      REG_LEFT_QX:    prdata = {16'b0, left_q[1]};
      REG_LEFT_QY:    prdata = {16'b0, left_q[2]};
      REG_LEFT_QZ:    prdata = {16'b0, left_q[3]};
      REG_LEFT_SCALE: prdata = left_scale;
      default:        prdata = '0;
    endcase
  end

  // input register with divisor magnitude
  assign in_scale = s_tdata[TDATA_W-1 -: POS_W];
  assign in_mag   = in_scale[POS_W-1] ? (~in_scale + 1'b1) : in_scale;

  always_ff @(posedge clk) begin
    if (rst) d_vld[0] <= 1'b0;
    else if (en) d_vld[0] <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_it[0].func   <= func_t'(s_tuser);
      d_it[0].pos[0] <= s_tdata[31:0];
      d_it[0].pos[1] <= s_tdata[63:32];
      d_it[0].pos[2] <= s_tdata[95:64];
      d_it[0].q[0]   <= s_tdata[111:96];
      d_it[0].q[1]   <= s_tdata[127:112];
      d_it[0].q[2]   <= s_tdata[143:128];
      d_it[0].q[3]   <= s_tdata[159:144];
      d_it[0].scale  <= in_scale;
      d_it[0].flag   <= 1'b0;
      d_it[0].zinv   <= 1'b0;
      d_mag[0]       <= in_mag;
      d_rem[0]       <= '0;
      d_num[0]       <= (DIV_W'(1) << (2 * POS_FRAC_BITS)) + DIV_W'(in_mag >> 1);
      d_quo[0]       <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [POS_W:0] shifted;
    logic           ge;
    assign shifted = {d_rem[k][POS_W-1:0], d_num[k][DIV_W-1]};
    assign ge      = shifted >= {1'b0, d_mag[k]};

    always_ff @(posedge clk) begin
      if (rst) d_vld[k+1] <= 1'b0;
      else if (en) d_vld[k+1] <= d_vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_it[k+1]  <= d_it[k];
        d_mag[k+1] <= d_mag[k];
        d_rem[k+1] <= ge ? (shifted - {1'b0, d_mag[k]}) : shifted;
        d_num[k+1] <= {d_num[k][DIV_W-2:0], 1'b0};
        d_quo[k+1] <= {d_quo[k][DIV_W-2:0], ge};
      end
    end
  end

  // inverse prep: conjugate, signed reciprocal, negated position
  always_comb begin
    wide_t rs;
    rs = wide_t'({1'b0, d_quo[DIV_W]});
    if (d_it[DIV_W].scale[POS_W-1]) rs = -rs;
    m0_it_next = d_it[DIV_W];
    if (d_it[DIV_W].func == FN_INVERT) begin
      for (int i = 0; i < 3; i++) begin
        m0_it_next.pos[i] = sat32(-wide_t'(d_it[DIV_W].pos[i]));
        m0_it_next.flag   = m0_it_next.flag | ovf32(-wide_t'(d_it[DIV_W].pos[i]));
      end
      for (int i = 1; i < 4; i++) begin
        m0_it_next.q[i] = sat16(-wide_t'(d_it[DIV_W].q[i]));
        m0_it_next.flag = m0_it_next.flag | ovf16(-wide_t'(d_it[DIV_W].q[i]));
      end
      if (d_it[DIV_W].scale == '0) begin
        m0_it_next.scale = '0;
        m0_it_next.zinv  = 1'b1;
      end else begin
        m0_it_next.scale = sat32(rs);
        m0_it_next.flag  = m0_it_next.flag | ovf32(rs);
      end
    end
  end

  // valid chain of the back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      m0_vld <= 1'b0;
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      r1_vld <= 1'b0;
      r2_vld <= 1'b0;
      r3_vld <= 1'b0;
      r4_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      o_vld  <= 1'b0;
    end else if (en) begin
      m0_vld <= d_vld[DIV_W];
      m1_vld <= m0_vld;
      m2_vld <= m1_vld;
      r1_vld <= m2_vld;
      r2_vld <= r1_vld;
      r3_vld <= r2_vld;
      r4_vld <= r3_vld;
      s1_vld <= r4_vld;
      s2_vld <= s1_vld;
      o_vld  <= s2_vld;
    end
  end

  // inverse prep and scaling of the negated position
  always_ff @(posedge clk) begin
    wide_t pr [3];
    item_t it_next;
    it_next = m1_it;
    for (int i = 0; i < 3; i++) begin
      pr[i] = rnd(wide_t'(m1_prod[i]), POS_FRAC_BITS);
      if (m1_it.func == FN_INVERT && ovf32(pr[i])) it_next.flag = 1'b1;
    end
    if (en) begin
      m0_it <= m0_it_next;
      m1_it <= m0_it;
      for (int i = 0; i < 3; i++) m1_prod[i] <= m0_it.pos[i] * m0_it.scale;
      m2_it <= it_next;
      for (int i = 0; i < 3; i++) begin
        if (m1_it.func == FN_INVERT) m2_vec[i] <= sat32(pr[i]);
        else m2_vec[i] <= m1_it.pos[i];
      end
    end
  end

  // rotation, first half: t = q (0,v)
  always_ff @(posedge clk) begin
    quat_t rq [4];
    for (int i = 0; i < 4; i++) rq[i] = (m2_it.func == FN_INVERT) ? m2_it.q[i] : left_q[i];
    if (en) begin
      r1_it    <= m2_it;
      r1_q     <= rq;
      r1_p[0]  <= rq[1] * m2_vec[0];
      r1_p[1]  <= rq[2] * m2_vec[1];
      r1_p[2]  <= rq[3] * m2_vec[2];
      r1_p[3]  <= rq[0] * m2_vec[0];
      r1_p[4]  <= rq[2] * m2_vec[2];
      r1_p[5]  <= rq[3] * m2_vec[1];
      r1_p[6]  <= rq[0] * m2_vec[1];
      r1_p[7]  <= rq[3] * m2_vec[0];
      r1_p[8]  <= rq[1] * m2_vec[2];
      r1_p[9]  <= rq[0] * m2_vec[2];
      r1_p[10] <= rq[1] * m2_vec[1];
      r1_p[11] <= rq[2] * m2_vec[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_it   <= r1_it;
      r2_q    <= r1_q;
      r2_t[0] <= T_W'(rnd(-(wide_t'(r1_p[0]) + wide_t'(r1_p[1]) + wide_t'(r1_p[2])),
                          QUAT_FRAC_BITS));
      r2_t[1] <= T_W'(rnd(wide_t'(r1_p[3]) + wide_t'(r1_p[4]) - wide_t'(r1_p[5]),
                          QUAT_FRAC_BITS));
      r2_t[2] <= T_W'(rnd(wide_t'(r1_p[6]) + wide_t'(r1_p[7]) - wide_t'(r1_p[8]),
                          QUAT_FRAC_BITS));
      r2_t[3] <= T_W'(rnd(wide_t'(r1_p[9]) + wide_t'(r1_p[10]) - wide_t'(r1_p[11]),
                          QUAT_FRAC_BITS));
    end
  end

  // rotation, second half: vector part of t conj(q)
  always_ff @(posedge clk) begin
    if (en) begin
      r3_it    <= r2_it;
      r3_p[0]  <= r2_t[0] * r2_q[1];
      r3_p[1]  <= r2_q[0] * r2_t[1];
      r3_p[2]  <= r2_t[2] * r2_q[3];
      r3_p[3]  <= r2_t[3] * r2_q[2];
      r3_p[4]  <= r2_t[0] * r2_q[2];
      r3_p[5]  <= r2_q[0] * r2_t[2];
      r3_p[6]  <= r2_t[3] * r2_q[1];
      r3_p[7]  <= r2_t[1] * r2_q[3];
      r3_p[8]  <= r2_t[0] * r2_q[3];
      r3_p[9]  <= r2_q[0] * r2_t[3];
      r3_p[10] <= r2_t[1] * r2_q[2];
      r3_p[11] <= r2_t[2] * r2_q[1];
    end
  end

  always_ff @(posedge clk) begin
    wide_t rs [3];
    item_t it_next;
    it_next = r3_it;
    for (int i = 0; i < 3; i++) begin
      rs[i] = rnd(-wide_t'(r3_p[4*i]) + wide_t'(r3_p[4*i+1]) - wide_t'(r3_p[4*i+2])
                  + wide_t'(r3_p[4*i+3]), QUAT_FRAC_BITS);
      if (ovf32(rs[i]) && (r3_it.func == FN_COMPOSE || r3_it.func == FN_APPLY
                           || r3_it.func == FN_INVERT))
        it_next.flag = 1'b1;
    end
    if (en) begin
      r4_it <= it_next;
      for (int i = 0; i < 3; i++) r4_r[i] <= sat32(rs[i]);
    end
  end

  // quaternion, scale and position products
  always_ff @(posedge clk) begin
    if (en) begin
      s1_it <= r4_it;
      s1_r  <= r4_r;
      for (int i = 0; i < 3; i++) s1_pp[i] <= r4_r[i] * left_scale;
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++) s1_qp[a][b] <= left_q[a] * r4_it.q[b];
      s1_sp <= r4_it.scale * left_scale;
    end
  end

  // round and saturate the products
  always_ff @(posedge clk) begin
    wide_t qs [4];
    wide_t pr [3];
    wide_t sr;
    logic  use_q;
    item_t it_next;
    qs[0] = wide_t'(s1_qp[0][0]) - wide_t'(s1_qp[1][1]) - wide_t'(s1_qp[2][2])
            - wide_t'(s1_qp[3][3]);
    qs[1] = wide_t'(s1_qp[0][1]) + wide_t'(s1_qp[1][0]) + wide_t'(s1_qp[2][3])
            - wide_t'(s1_qp[3][2]);
    qs[2] = wide_t'(s1_qp[0][2]) - wide_t'(s1_qp[1][3]) + wide_t'(s1_qp[2][0])
            + wide_t'(s1_qp[3][1]);
    qs[3] = wide_t'(s1_qp[0][3]) + wide_t'(s1_qp[1][2]) - wide_t'(s1_qp[2][1])
            + wide_t'(s1_qp[3][0]);
    for (int i = 0; i < 4; i++) qs[i] = rnd(qs[i], QUAT_FRAC_BITS);
    for (int i = 0; i < 3; i++) pr[i] = rnd(wide_t'(s1_pp[i]), POS_FRAC_BITS);
    sr    = rnd(wide_t'(s1_sp), POS_FRAC_BITS);
    use_q = s1_it.func == FN_COMPOSE || s1_it.func == FN_LQUAT || s1_it.func == FN_QUAT_IN;
    it_next = s1_it;
    for (int i = 0; i < 4; i++)
      if (use_q && ovf16(qs[i])) it_next.flag = 1'b1;
    for (int i = 0; i < 3; i++)
      if (ovf32(pr[i]) && (s1_it.func == FN_COMPOSE || s1_it.func == FN_APPLY))
        it_next.flag = 1'b1;
    if (ovf32(sr) && (s1_it.func == FN_COMPOSE || s1_it.func == FN_SCALE))
      it_next.flag = 1'b1;
    if (en) begin
      s2_it <= it_next;
      s2_r  <= s1_r;
      for (int i = 0; i < 4; i++) s2_q[i] <= sat16(qs[i]);
      for (int i = 0; i < 3; i++) s2_pos[i] <= sat32(pr[i]);
      s2_s <= sat32(sr);
    end
  end

  // position add and result select
  always_ff @(posedge clk) begin
    wide_t sum [3];
    logic  add_flag;
    logic  use_add;
    use_add  = s2_it.func == FN_COMPOSE || s2_it.func == FN_APPLY
               || s2_it.func == FN_TRANSLATE;
    add_flag = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum[i] = wide_t'((s2_it.func == FN_TRANSLATE) ? s2_it.pos[i] : s2_pos[i])
               + wide_t'(left_pos[i]);
      if (use_add && ovf32(sum[i])) add_flag = 1'b1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        case (s2_it.func)
          FN_COMPOSE, FN_APPLY, FN_TRANSLATE: o_pos[i] <= sat32(sum[i]);
          FN_INVERT:                          o_pos[i] <= s2_r[i];
          FN_LQUAT:                           o_pos[i] <= left_pos[i];
          FN_QUAT_IN, FN_SCALE:               o_pos[i] <= s2_it.pos[i];
          default:                            o_pos[i] <= '0;
        endcase
      end
      for (int i = 0; i < 4; i++) begin
        case (s2_it.func)
          FN_COMPOSE, FN_LQUAT, FN_QUAT_IN:   o_q[i] <= s2_q[i];
          FN_INVERT, FN_TRANSLATE, FN_SCALE:  o_q[i] <= s2_it.q[i];
          default:                            o_q[i] <= '0;
        endcase
      end
      case (s2_it.func)
        FN_COMPOSE, FN_SCALE:                 o_scale <= s2_s;
        FN_INVERT, FN_QUAT_IN, FN_TRANSLATE:  o_scale <= s2_it.scale;
        FN_LQUAT:                             o_scale <= left_scale;
        default:                              o_scale <= '0;
      endcase
      if (s2_it.func == FN_INVERT && s2_it.zinv) o_status <= ST_ZERO_INV;
      else if (s2_it.flag || add_flag)         o_status <= ST_SAT;
      else                                      o_status <= ST_OK;
    end
  end

  // output beat
  assign m_tvalid = o_vld;
  assign m_tdata  = {o_scale, o_q[3], o_q[2], o_q[1], o_q[0], o_pos[2], o_pos[1], o_pos[0]};
  assign m_tuser  = o_status;

endmodule

/* hw/rtl/stu_checker.sv */
`timescale 1ns / 1ps
module stu_props (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [stu_pkg::TDATA_W-1:0] m_tdata,
  input logic [stu_pkg::STAT_W-1:0]  m_tuser
);
  import stu_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // input side only blocks behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("ready low without output stall");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat after reset");

  // status code is never the unused value
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("bad status code");

  // zero scale inverse gives zero scale and zero position
  a_zinv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ZERO_INV |->
      m_tdata[TDATA_W-1 -: POS_W] == '0 && m_tdata[3*POS_W-1:0] == '0)
    else $error("zero scale inverse not cleared");

endmodule

bind similarity_transform_unit stu_props u_stu_props (.*);

/* dv/stu_checker.sv */
`timescale 1ns / 1ps
module stu_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [stu_pkg::TDATA_W-1:0] s_tdata,
  input  logic [stu_pkg::FUNC_W-1:0]  s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [stu_pkg::TDATA_W-1:0] m_tdata,
  input  logic [stu_pkg::STAT_W-1:0]  m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stu_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending
);
  import stu_pkg::*;

  typedef longint vec3_t[3];
  typedef longint vec4_t[4];

  typedef struct packed {
    logic [TDATA_W-1:0] data;
    logic [STAT_W-1:0]  stat;
  } xf_beat_t;

  localparam longint QW_IDENT    = 32767;
  localparam longint SCALE_IDENT = 65536;

  // field layout of tdata, lowest bit up
  localparam int FLD_LO[8] = '{0, 32, 64, 96, 112, 128, 144, 160};
  localparam int FLD_W[8]  = '{32, 32, 32, 16, 16, 16, 16, 32};

  xf_beat_t expected_q[$];
  longint   lp[3];
  longint   lq[4];
  longint   ls;
  bit       sat_hit;

  assign pending = expected_q.size();

  function automatic longint rshift_rnd(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      sat_hit = 1;
      return hi;
    end
    if (x < lo) begin
      sat_hit = 1;
      return lo;
    end
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clip(rshift_rnd(a * b, POS_FRAC_BITS), 32);
  endfunction

  // hamilton product
  function automatic void hamilton(input vec4_t a, input vec4_t b, output vec4_t r);
    longint w, x, y, z;
    w = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    x = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
    y = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
    z = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
    r[0] = clip(rshift_rnd(w, QUAT_FRAC_BITS), 16);
    r[1] = clip(rshift_rnd(x, QUAT_FRAC_BITS), 16);
    r[2] = clip(rshift_rnd(y, QUAT_FRAC_BITS), 16);
    r[3] = clip(rshift_rnd(z, QUAT_FRAC_BITS), 16);
  endfunction

  // q (0,v) conj(q), intermediate kept wide
  function automatic void rotate(input vec4_t q, input vec3_t v, output vec3_t r);
    longint tw, tx, ty, tz;
    tw = rshift_rnd(-(q[1]*v[0] + q[2]*v[1] + q[3]*v[2]), QUAT_FRAC_BITS);
    tx = rshift_rnd(q[0]*v[0] + q[2]*v[2] - q[3]*v[1], QUAT_FRAC_BITS);
    ty = rshift_rnd(q[0]*v[1] + q[3]*v[0] - q[1]*v[2], QUAT_FRAC_BITS);
    tz = rshift_rnd(q[0]*v[2] + q[1]*v[1] - q[2]*v[0], QUAT_FRAC_BITS);
    r[0] = clip(rshift_rnd(-tw*q[1] + q[0]*tx - ty*q[3] + tz*q[2], QUAT_FRAC_BITS), 32);
    r[1] = clip(rshift_rnd(-tw*q[2] + q[0]*ty - tz*q[1] + tx*q[3], QUAT_FRAC_BITS), 32);
    r[2] = clip(rshift_rnd(-tw*q[3] + q[0]*tz - tx*q[2] + ty*q[1], QUAT_FRAC_BITS), 32);
  endfunction

  // rotate, scale, then translate by the left transform
  function automatic void left_apply(input vec3_t v, output vec3_t r);
    vec3_t t;
    rotate(lq, v, t);
    for (int i = 0; i < 3; i++) r[i] = clip(fx_mul(t[i], ls) + lp[i], 32);
  endfunction

  function automatic xf_beat_t predict_transform(logic [2:0] fn, logic [TDATA_W-1:0] d);
    vec3_t    tp, rp, v;
    vec4_t    tq, rq;
    longint   ts, rs, mag, qv;
    logic [STAT_W-1:0] st;
    xf_beat_t b;
    sat_hit = 0;
    st = ST_OK;
    for (int i = 0; i < 3; i++) tp[i] = longint'($signed(d[32*i +: 32]));
    for (int i = 0; i < 4; i++) tq[i] = longint'($signed(d[96 + 16*i +: 16]));
    ts = longint'($signed(d[160 +: 32]));
    rp = '{0, 0, 0};
    rq = '{0, 0, 0, 0};
    rs = 0;
    case (func_t'(fn))
      FN_COMPOSE: begin
        hamilton(lq, tq, rq);
        rs = fx_mul(ls, ts);
        left_apply(tp, rp);
      end
      FN_APPLY: left_apply(tp, rp);
      FN_INVERT: begin
        rq[0] = tq[0];
        for (int i = 1; i < 4; i++) rq[i] = clip(-tq[i], 16);
        if (ts == 0) begin
          rs = 0;
          st = ST_ZERO_INV;
        end else begin
          mag = (ts < 0) ? -ts : ts;
          qv = ((longint'(1) <<< (2 * POS_FRAC_BITS)) + mag / 2) / mag;
          rs = clip((ts < 0) ? -qv : qv, 32);
        end
        for (int i = 0; i < 3; i++) v[i] = fx_mul(clip(-tp[i], 32), rs);
        rotate(rq, v, rp);
      end
      FN_LQUAT: begin
        rp = lp;
        rs = ls;
        hamilton(lq, tq, rq);
      end
      FN_QUAT_IN: begin
        rp = tp;
        rs = ts;
        hamilton(lq, tq, rq);
      end
      FN_TRANSLATE: begin
        for (int i = 0; i < 3; i++) rp[i] = clip(tp[i] + lp[i], 32);
        rq = tq;
        rs = ts;
      end
      FN_SCALE: begin
        rp = tp;
        rq = tq;
        rs = fx_mul(ts, ls);
      end
      default: ;
    endcase
    if (st == ST_OK && sat_hit) st = ST_SAT;
    for (int i = 0; i < 3; i++) b.data[32*i +: 32] = rp[i][31:0];
    for (int i = 0; i < 4; i++) b.data[96 + 16*i +: 16] = rq[i][15:0];
    b.data[160 +: 32] = rs[31:0];
    b.stat = st;
    return b;
  endfunction

  // left transform copy follows apb writes
  always @(posedge clk) begin
    if (rst) begin
      lp = '{0, 0, 0};
      lq = '{QW_IDENT, 0, 0, 0};
      ls = SCALE_IDENT;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_LEFT_POS_X: lp[0] = longint'($signed(pwdata));
        REG_LEFT_POS_Y: lp[1] = longint'($signed(pwdata));
        REG_LEFT_POS_Z: lp[2] = longint'($signed(pwdata));
        REG_LEFT_QW:    lq[0] = longint'($signed(pwdata[15:0]));
        REG_LEFT_QX:    lq[1] = longint'($signed(pwdata[15:0]));
        REG_LEFT_QY:    lq[2] = longint'($signed(pwdata[15:0]));
        REG_LEFT_QZ:    lq[3] = longint'($signed(pwdata[15:0]));
        REG_LEFT_SCALE: ls    = longint'($signed(pwdata));
        default: ;
      endcase
    end
  end

  // predict on input beats
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_q.push_back(predict_transform(s_tuser, s_tdata));
  end

  // compare output beats with the oldest prediction
  always @(posedge clk) begin
    xf_beat_t exp_b;
    longint   ev, av;
    if (rst) begin
      errors = 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output beat data=%h status=%0d", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_b = expected_q.pop_front();
        for (int i = 0; i < 8; i++) begin
          ev = longint'((exp_b.data >> FLD_LO[i]) & ((192'd1 << FLD_W[i]) - 1));
          av = longint'((m_tdata >> FLD_LO[i]) & ((192'd1 << FLD_W[i]) - 1));
          if (ev != av) begin
            $display("%0t: field %0d expected %h actual %h", $time, i, ev, av);
            errors++;
          end
        end
        if (exp_b.stat != m_tuser) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_b.stat, m_tuser);
          errors++;
        end
      end
    end
  end

endmodule

/* dv/similarity_transform_unit_tb.sv */
`timescale 1ns / 1ps
module similarity_transform_unit_tb;
  import stu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [31:0] P_MAX = 32'h7fffffff;
  localparam logic [31:0] P_MIN = 32'h80000000;
  localparam logic [15:0] Q_MAX = 16'h7fff;
  localparam logic [15:0] Q_MIN = 16'h8000;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic [FUNC_W-1:0]  s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]  m_tuser;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int errors;
  int pending;
  int idle_cycles;
  bit hold_req;
  bit no_idle;

  similarity_transform_unit dut (.*);

  stu_checker checker_i (.*);

  initial clk = 0;
  always #10 clk = ~clk;

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    hold_req = 0;
    no_idle = 0;
  end

  // watchdog on cycles without any accepted beat or apb select
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("similarity_transform_unit test failed");
        $finish;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (no_idle) begin
        m_tready <= 1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else if ($urandom_range(0, 9) < 2) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 50);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return P_MAX;
      1: return P_MIN;
      2: return '0;
      3, 4: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_left(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz, logic [31:0] sc);
    wait_drained();
    apb_write(REG_LEFT_POS_X, px);
    apb_write(REG_LEFT_POS_Y, py);
    apb_write(REG_LEFT_POS_Z, pz);
    apb_write(REG_LEFT_QW, {16'h0, qw});
    apb_write(REG_LEFT_QX, {16'h0, qx});
    apb_write(REG_LEFT_QY, {16'h0, qy});
    apb_write(REG_LEFT_QZ, {16'h0, qz});
    apb_write(REG_LEFT_SCALE, sc);
  endtask

  // one input beat, then an optional gap
  task automatic send_beat(logic [2:0] fn, logic [TDATA_W-1:0] d);
    int gap;
    s_tvalid <= 1;
    s_tdata <= d;
    s_tuser <= fn;
    do @(posedge clk); while (!s_tready);
    if (no_idle || hold_req) gap = 0;
    else if ($urandom_range(0, 9) < 7) gap = 0;
    else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int n);
    logic [2:0]         fn;
    logic [TDATA_W-1:0] d;
    for (int k = 0; k < n; k++) begin
      fn = ($urandom_range(0, 49) == 0) ? FN_NONE : 3'($urandom_range(0, 6));
      d = {pick32(), pick16(), pick16(), pick16(), pick16(), pick32(), pick32(), pick32()};
      // a zero scale now and then for the inverse
      if (fn == FN_INVERT && $urandom_range(0, 7) == 0) d[191:160] = '0;
      if ((k % 60) == 30) no_idle = !no_idle;
      send_beat(fn, d);
    end
    s_tvalid <= 0;
    no_idle = 0;
  endtask

  initial begin
    logic [TDATA_W-1:0] d;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every function on extreme operands, identity left transform
    for (int f = 0; f < 8; f++) begin
      d = {P_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, P_MAX, P_MAX, P_MAX};
      send_beat(3'(f), d);
      d = {P_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, P_MIN, P_MIN, P_MIN};
      send_beat(3'(f), d);
    end
    send_beat(FN_INVERT, {32'h0, 16'h0, 16'h0, 16'h0, Q_MAX, 32'h10000, 32'h0, 32'hffff0000});
    send_beat(FN_INVERT, {32'h1, 16'h0, 16'h0, 16'h0, Q_MAX, 32'h10000, 32'h0, 32'h0});
    send_beat(FN_INVERT, {32'hffff8000, 16'h5a82, 16'h0, 16'h0, 16'h5a82, P_MAX, 32'h1, P_MIN});
    send_beat(FN_APPLY, {32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h30000, 32'h20000, 32'h10000});
    s_tvalid <= 0;
    send_random(120);

    // moderate rotation by 90 degrees about z, scale two
    load_left(32'h00050000, 32'hfffd0000, 32'h00000100, 16'h5a82, 16'h0, 16'h0,
              16'h5a82, 32'h00020000);
    send_random(140);

    // all registers at their maximum
    load_left(P_MAX, P_MAX, P_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, P_MAX);
    send_random(140);

    // all registers at their minimum
    load_left(P_MIN, P_MIN, P_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, P_MIN);
    send_random(140);

    // random left transform, receiver held off while the sender keeps going
    load_left($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 32'($urandom_range(0, 262143)));
    hold_req = 1;
    send_random(140);
    wait_drained();

    // random left transform, scale kept between zero and two
    load_left(pick32(), pick32(), pick32(), pick16(), pick16(), pick16(), pick16(),
              32'($urandom_range(0, 131072)));
    send_random(140);

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("similarity_transform_unit test passed");
    end else begin
      $display("similarity_transform_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/stu_pkg.sv
hw/rtl/similarity_transform_unit.sv
hw/rtl/stu_checker.sv
dv/stu_checker.sv
dv/similarity_transform_unit_tb.sv
